[hw/rtl/gie_pkg.sv]
`default_nettype none

package gie_pkg;

  // Field size and derived widths.
  localparam int FIELD_DEGREE = 10;
  localparam int POLY_W       = FIELD_DEGREE + 1;
  localparam int DEG_W        = $clog2(POLY_W);
  localparam int IN_TDATA_W   = ((FIELD_DEGREE + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((FIELD_DEGREE + 7) / 8) * 8;

  // x^10 + x^3 + 1
  localparam logic [POLY_W-1:0] MODULUS_RESET = POLY_W'(11'd1033);

  // Microprogram addressing.
  localparam int PC_W = 2;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT = 2'd0;
  localparam pc_t PC_TEST = 2'd1;
  localparam pc_t PC_STEP = 2'd2;
  localparam pc_t PC_EMIT = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_STEP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NO_INPUT,
    COND_R1_ZERO,
    COND_STEP_MORE,
    COND_OUT_BLOCKED
  } cond_t;

  // One control word: operation, jump condition, target when the
  // condition holds and successor when it does not.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    pc_t   next_pc;
  } uword_t;

  typedef struct packed {
    logic r1_zero;
    logic step_more;
  } dp_status_t;

  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    case (pc)
      PC_WAIT: w = '{op: OP_ACCEPT, cond: COND_NO_INPUT,    target: PC_WAIT, next_pc: PC_TEST};
      PC_TEST: w = '{op: OP_NOP,    cond: COND_R1_ZERO,     target: PC_EMIT, next_pc: PC_STEP};
      PC_STEP: w = '{op: OP_STEP,   cond: COND_STEP_MORE,   target: PC_STEP, next_pc: PC_EMIT};
      PC_EMIT: w = '{op: OP_EMIT,   cond: COND_OUT_BLOCKED, target: PC_EMIT, next_pc: PC_WAIT};
      default: w = '{op: OP_NOP,    cond: COND_NO_INPUT,    target: PC_WAIT, next_pc: PC_WAIT};
    endcase
    return w;
  endfunction

  // Position of the highest set bit; zero input gives zero.
  function automatic logic [DEG_W-1:0] lead_degree(logic [POLY_W-1:0] p);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int i = 0; i < POLY_W; i++) begin
      if (p[i]) begin
        d = DEG_W'(i);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gie_sequencer.sv]
`default_nettype none

module gie_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               out_blocked,
  input  wire gie_pkg::dp_status_t status,
  output gie_pkg::uword_t          uword
);

  gie_pkg::pc_t pc;
  gie_pkg::pc_t pc_next;
  logic         cond_true;

  assign uword = gie_pkg::ucode_rom(pc);

  always_comb begin
    case (uword.cond)
      gie_pkg::COND_NO_INPUT:    cond_true = !in_valid;
      gie_pkg::COND_R1_ZERO:     cond_true = status.r1_zero;
      gie_pkg::COND_STEP_MORE:   cond_true = status.step_more;
      gie_pkg::COND_OUT_BLOCKED: cond_true = out_blocked;
      default:                   cond_true = 1'b0;
    endcase
  end

  assign pc_next = cond_true ? uword.target : uword.next_pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= gie_pkg::PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gie_datapath.sv]
`default_nettype none

module gie_datapath (
  input  wire logic                              clk,
  input  wire gie_pkg::op_t                      op,
  input  wire logic                              load,
  input  wire logic [gie_pkg::POLY_W-1:0]        modulus,
  input  wire logic [gie_pkg::FIELD_DEGREE-1:0]  operand,
  output gie_pkg::dp_status_t                    status,
  output logic                                   gcd_one,
  output logic [gie_pkg::FIELD_DEGREE-1:0]       cofactor
);

  // Remainder pair and the matching w cofactors, kept modulo x^M.
  logic [gie_pkg::POLY_W-1:0]       r0, r1;
  logic [gie_pkg::FIELD_DEGREE-1:0] w0, w1;

  logic [gie_pkg::DEG_W-1:0] deg0, deg1, shamt;
  logic                      r0_zero;
  logic                      do_swap;

  assign deg0    = gie_pkg::lead_degree(r0);
  assign deg1    = gie_pkg::lead_degree(r1);
  assign r0_zero = (r0 == '0);
  // When the older remainder drops below the newer one the division round
  // is over and the roles exchange.
  assign do_swap = r0_zero || (deg0 < deg1);
  assign shamt   = deg0 - deg1;

  assign status = '{r1_zero: (r1 == '0), step_more: !(do_swap && r0_zero)};

  assign gcd_one  = (r0 == gie_pkg::POLY_W'(1));
  assign cofactor = w0;

  always_ff @(posedge clk) begin
    if (op == gie_pkg::OP_ACCEPT && load) begin
      r0 <= modulus;
      r1 <= gie_pkg::POLY_W'(operand);
      w0 <= '0;
      w1 <= gie_pkg::FIELD_DEGREE'(1);
    end else if (op == gie_pkg::OP_STEP) begin
      if (do_swap) begin
        r0 <= r1;
        r1 <= r0;
        w0 <= w1;
        w1 <= w0;
      end else begin
        r0 <= r0 ^ (r1 << shamt);
        w0 <= w0 ^ (w1 << shamt);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gf2m_inverse_ext_euclid_core.sv]
`default_nettype none

// Inverter for GF(2^M), M = 10, by the extended Euclidean algorithm.
//
// Channels: the slave stream takes one item per field element to invert
// (operand in s_axis_tdata). The master stream returns one item per input:
// the inverse in m_axis_tdata and, in m_axis_tuser, a flag that is set when
// the gcd with the modulus is 1. With the flag clear the inverse reads 0.
// The modulus polynomial sits in a register written through the cfg channel;
// cfg_ready is always high. Write it only while no item is in flight.
//
// Sequence: an item is accepted in the wait step and passes the test step,
// which goes straight to emit for a zero operand; then come the shift-reduce
// or swap steps of the remainder pair, then the emit step that loads the
// output register and waits there while it is blocked. All steps run on the
// single shared shift-reduce datapath walked by the microprogram.
//
// Reset (rst, synchronous) returns the sequencer to its wait step, empties
// the output register and loads the modulus x^10 + x^3 + 1. When the
// receiver stalls, a finished result waits in the output register; the
// block still accepts and works on the next item and holds it in the emit
// step until the register frees up.
module gf2m_inverse_ext_euclid_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Slave stream, tdata: operand [9:0], zeros above.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [gie_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Master stream, tdata: inverse [9:0], zeros above.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [gie_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // tuser: has_inverse [0].
  output logic [0:0]                              m_axis_tuser,
  // Configuration write channel: modulus_poly.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gie_pkg::POLY_W-1:0]         cfg_data
);

  logic [gie_pkg::POLY_W-1:0]       modulus_poly;
  gie_pkg::uword_t                  uword;
  gie_pkg::dp_status_t              status;
  logic                             gcd_one;
  logic [gie_pkg::FIELD_DEGREE-1:0] cofactor;
  logic                             in_fire;
  logic                             out_blocked;
  logic                             out_load;
  logic [gie_pkg::FIELD_DEGREE-1:0] inverse;
  logic                             has_inverse;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_poly <= gie_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus_poly <= cfg_data;
    end
  end

  // The input is open only in the wait step of the microprogram.
  assign s_axis_tready = (uword.op == gie_pkg::OP_ACCEPT);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // The output register is full and the receiver is not taking it.
  assign out_blocked = m_axis_tvalid && !m_axis_tready;
  assign out_load    = (uword.op == gie_pkg::OP_EMIT) && !out_blocked;

  gie_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .out_blocked(out_blocked),
    .status     (status),
    .uword      (uword)
  );

  gie_datapath u_dp (
    .clk     (clk),
    .op      (uword.op),
    .load    (in_fire),
    .modulus (modulus_poly),
    .operand (s_axis_tdata[gie_pkg::FIELD_DEGREE-1:0]),
    .status  (status),
    .gcd_one (gcd_one),
    .cofactor(cofactor)
  );

  // Output register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      has_inverse <= gcd_one;
      inverse     <= gcd_one ? cofactor : '0;
    end
  end

  assign m_axis_tdata = gie_pkg::OUT_TDATA_W'(inverse);
  assign m_axis_tuser = has_inverse;

  // One item at a time: right after an accept the input closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while an item is still in work");

  // A new result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result register overwritten while stalled");

  // Without an inverse the data field is zero.
  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero inverse reported without an inverse");

  // Input and output never move in the same microprogram step.
  a_accept_emit_apart: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !out_load)
    else $error("accept and emit in one step");

endmodule

`default_nettype wire
